// ----- sv/sbfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial boot frame receiver package
// Constants and command and status bundles shared by the frame receiver
// controller and datapath, and the CRC-32 byte update used by the datapath.
// ----------------------------------------------------------------------------
package sbfr_pkg;

  // Default payload store depth.
  localparam int MAX_PAYLOAD_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd1;
  localparam int CFG_DATA_W = 16;

  // Configuration reset values.
  localparam logic [15:0] BYTE_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd5000;

  // Command bytes received in idle.
  localparam logic [7:0] CMD_ADDR = 8'hAA;
  localparam logic [7:0] CMD_DATA = 8'hDD;
  localparam logic [7:0] CMD_PING = 8'hCC;

  // Reply bytes.
  localparam logic [7:0] TX_ACK  = 8'hFF;
  localparam logic [7:0] TX_NACK = 8'h00;

  // Result kinds.
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       tick;         // count one tick on both timers
    logic       open_frame;   // start a new frame
    logic       open_addr;    // the new frame is an address frame
    logic       clr_wait;     // a frame byte arrived
    logic       load_len;     // capture the length byte
    logic       shift_crc;    // shift in one expected CRC byte
    logic       take_payload; // store one payload byte and update the CRC
    logic       load_ptr;     // load the write pointer from the address frame
    logic       advance_ptr;  // advance the write pointer by the frame length
    logic       commit_clr;   // restart the commit index
    logic       commit_inc;   // step the commit index
    logic       emit;         // load the output register
    logic [1:0] emit_kind;
    logic [7:0] emit_tx;
    logic       emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;         // output register can take a result this cycle
    logic idle_tick_expire; // a tick now would exceed the idle limit
    logic idle_expired;     // idle limit already exceeded
    logic wait_tick_expire; // a tick now would exceed the byte limit
    logic is_addr_cmd;
    logic is_data_cmd;
    logic is_ping_cmd;
    logic byte_zero;
    logic crc_last;         // this is the fourth CRC byte
    logic payload_last;     // this is the final payload byte
    logic frame_ok;         // CRC and length checks pass
    logic frame_is_addr;
    logic len_is_4;
    logic len_zero;
    logic commit_last;      // current commit index is the final byte
  } dp_stat_t;

  // One byte of the reflected CRC-32 update.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/serial_boot_frame_receiver.sv -----
`default_nettype none
// Timing: a single reply to an accepted byte or tick appears in the output
// register on the next cycle. After the last byte of a frame the input
// stalls for the check state, then a store read and an output load per
// written byte and the final ack; output stalls add to these.
// Throughput: one item per cycle outside frame ends and output stalls.
// Reset: asynchronous, clears control state and timers; no clearing pass.
// ----------------------------------------------------------------------------
// Serial boot frame receiver
// Receives bootloader bytes and millisecond ticks, checks CRC-32 framed
// address and data commands, and emits replies, byte writes and timeouts.
// ----------------------------------------------------------------------------
module serial_boot_frame_receiver #(
  parameter int MAX_PAYLOAD = sbfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire                              operation_i,
  input  wire  [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [1:0]                       kind_o,
  output logic [7:0]                       tx_byte_o,
  output logic [31:0]                      write_address_o,
  output logic [7:0]                       write_data_o,
  output logic                             last_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [sbfr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [sbfr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  sbfr_pkg::dp_cmd_t  cmd;
  sbfr_pkg::dp_stat_t stat;

  // Configuration writes are always accepted.
  assign cfg_ready_o = 1'b1;

  sbfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sbfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_byte_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .tx_byte_o       (tx_byte_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

// ----- sv/sbfr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial boot frame receiver controller
// Frame state machine: decodes commands in idle, walks through the length,
// CRC and payload bytes, and sequences the check and the write burst.
// ----------------------------------------------------------------------------
module sbfr_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 operation_i,
  input  sbfr_pkg::dp_stat_t  stat_i,
  output sbfr_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LENGTH,
    ST_CRC,
    ST_PAYLOAD,
    ST_DEAD,
    ST_FINISH,
    ST_READ,
    ST_WRITE,
    ST_ACK
  } state_e;

  state_e state_q, state_d;
  logic   take_input;
  logic   accept;

  // Inputs are taken only in the byte-receiving states and when a result fits.
  always_comb begin
    case (state_q)
      ST_IDLE, ST_LENGTH, ST_CRC, ST_PAYLOAD, ST_DEAD: take_input = 1'b1;
      default:                                         take_input = 1'b0;
    endcase
  end

  assign in_stall_o = !take_input || !stat_i.out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == sbfr_pkg::OP_TICK) begin
            cmd_o.tick = 1'b1;
            if (stat_i.idle_tick_expire) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = sbfr_pkg::KIND_TIMEOUT;
              cmd_o.emit_last = 1'b1;
              state_d         = ST_DEAD;
            end
          end else if (stat_i.idle_expired) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = sbfr_pkg::KIND_TIMEOUT;
            cmd_o.emit_last = 1'b1;
            state_d         = ST_DEAD;
          end else if (stat_i.is_addr_cmd) begin
            cmd_o.open_frame = 1'b1;
            cmd_o.open_addr  = 1'b1;
            state_d          = ST_LENGTH;
          end else if (stat_i.is_data_cmd) begin
            cmd_o.open_frame = 1'b1;
            state_d          = ST_LENGTH;
          end else if (stat_i.is_ping_cmd) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = sbfr_pkg::KIND_TX;
            cmd_o.emit_tx   = sbfr_pkg::TX_ACK;
            cmd_o.emit_last = 1'b1;
          end
        end
      end
      ST_LENGTH, ST_CRC, ST_PAYLOAD: begin
        if (accept) begin
          if (operation_i == sbfr_pkg::OP_TICK) begin
            cmd_o.tick = 1'b1;
            if (stat_i.wait_tick_expire) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = sbfr_pkg::KIND_TX;
              cmd_o.emit_tx   = sbfr_pkg::TX_NACK;
              cmd_o.emit_last = 1'b1;
              state_d         = ST_IDLE;
            end
          end else begin
            cmd_o.clr_wait = 1'b1;
            if (state_q == ST_LENGTH) begin
              cmd_o.load_len = 1'b1;
              state_d        = stat_i.byte_zero ? ST_FINISH : ST_CRC;
            end else if (state_q == ST_CRC) begin
              cmd_o.shift_crc = 1'b1;
              if (stat_i.crc_last) begin
                state_d = ST_PAYLOAD;
              end
            end else begin
              cmd_o.take_payload = 1'b1;
              if (stat_i.payload_last) begin
                state_d = ST_FINISH;
              end
            end
          end
        end
      end
      ST_FINISH: begin
        // Judge the frame once the last byte has been folded into the CRC.
        if (stat_i.out_free) begin
          cmd_o.emit_kind = sbfr_pkg::KIND_TX;
          cmd_o.emit_last = 1'b1;
          cmd_o.emit_tx   = sbfr_pkg::TX_NACK;
          if (!stat_i.frame_ok) begin
            cmd_o.emit = 1'b1;
            state_d    = ST_IDLE;
          end else if (stat_i.frame_is_addr) begin
            cmd_o.emit = 1'b1;
            if (stat_i.len_is_4) begin
              cmd_o.load_ptr = 1'b1;
              cmd_o.emit_tx  = sbfr_pkg::TX_ACK;
            end
            state_d = ST_IDLE;
          end else if (stat_i.len_zero) begin
            cmd_o.emit    = 1'b1;
            cmd_o.emit_tx = sbfr_pkg::TX_ACK;
            state_d       = ST_IDLE;
          end else begin
            cmd_o.commit_clr = 1'b1;
            state_d          = ST_READ;
          end
        end
      end
      ST_READ: begin
        // The store read for the current index completes in this cycle.
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = sbfr_pkg::KIND_WRITE;
          if (stat_i.commit_last) begin
            state_d = ST_ACK;
          end else begin
            cmd_o.commit_inc = 1'b1;
            state_d          = ST_READ;
          end
        end
      end
      ST_ACK: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_kind   = sbfr_pkg::KIND_TX;
          cmd_o.emit_tx     = sbfr_pkg::TX_ACK;
          cmd_o.emit_last   = 1'b1;
          cmd_o.advance_ptr = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_DEAD: begin
        // Sticky timeout: inputs are taken and dropped.
        state_d = ST_DEAD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/sbfr_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Serial boot frame receiver datapath
// Timers, configuration registers, frame fields, running CRC, payload store,
// write pointer and the output register.
// ----------------------------------------------------------------------------
module sbfr_datapath #(
  parameter int MAX_PAYLOAD = sbfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire  [7:0]                        rx_byte_i,
  input  wire                               cfg_we_i,
  input  wire  [sbfr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [sbfr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  sbfr_pkg::dp_cmd_t                 cmd_i,
  output sbfr_pkg::dp_stat_t                stat_o,
  input  wire                               out_stall_i,
  output logic                              out_valid_o,
  output logic [1:0]                        kind_o,
  output logic [7:0]                        tx_byte_o,
  output logic [31:0]                       write_address_o,
  output logic [7:0]                        write_data_o,
  output logic                              last_o
);

  localparam int AW = $clog2(MAX_PAYLOAD);
  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic [15:0]   byte_limit_q, idle_limit_q;
  logic [15:0]   idle_q, wait_q;
  logic [15:0]   idle_next, wait_next;
  logic          is_addr_q;
  logic [7:0]    len_q, left_q, pidx_q;
  logic [1:0]    crc_cnt_q;
  logic [31:0]   exp_crc_q, crc_q, addr_shift_q, ptr_q;
  logic [AW-1:0] cidx_q;
  logic [7:0]    store [MAX_PAYLOAD];
  logic [7:0]    rd_data_q;
  logic          out_valid_q, out_last_q;
  logic [1:0]    out_kind_q;
  logic [7:0]    out_tx_q, out_data_q;
  logic [31:0]   out_addr_q;

  // Saturating timer increments.
  assign idle_next = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign wait_next = (wait_q == 16'hFFFF) ? wait_q : wait_q + 16'd1;

  // Status toward the controller.
  always_comb begin
    stat_o                  = '0;
    stat_o.out_free         = !out_valid_q || !out_stall_i;
    stat_o.idle_tick_expire = idle_next > idle_limit_q;
    stat_o.idle_expired     = idle_q > idle_limit_q;
    stat_o.wait_tick_expire = wait_next > byte_limit_q;
    stat_o.is_addr_cmd      = rx_byte_i == sbfr_pkg::CMD_ADDR;
    stat_o.is_data_cmd      = rx_byte_i == sbfr_pkg::CMD_DATA;
    stat_o.is_ping_cmd      = rx_byte_i == sbfr_pkg::CMD_PING;
    stat_o.byte_zero        = rx_byte_i == 8'd0;
    stat_o.crc_last         = crc_cnt_q == 2'd3;
    stat_o.payload_last     = left_q == 8'd1;
    stat_o.frame_ok         = ((len_q == 8'd0) || ((~crc_q) == exp_crc_q))
                              && (len_q <= MaxLen);
    stat_o.frame_is_addr    = is_addr_q;
    stat_o.len_is_4         = len_q == 8'd4;
    stat_o.len_zero         = len_q == 8'd0;
    stat_o.commit_last      = (8'(cidx_q) + 8'd1) == len_q;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q <= sbfr_pkg::BYTE_TIMEOUT_RST;
      idle_limit_q <= sbfr_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sbfr_pkg::REG_BYTE_TIMEOUT: byte_limit_q <= cfg_data_i;
        sbfr_pkg::REG_IDLE_TIMEOUT: idle_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Timers, frame fields, CRC and write pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q       <= '0;
      wait_q       <= '0;
      is_addr_q    <= 1'b0;
      len_q        <= '0;
      left_q       <= '0;
      pidx_q       <= '0;
      crc_cnt_q    <= '0;
      exp_crc_q    <= '0;
      crc_q        <= '1;
      addr_shift_q <= '0;
      ptr_q        <= '0;
      cidx_q       <= '0;
    end else begin
      if (cmd_i.tick) begin
        idle_q <= idle_next;
        wait_q <= wait_next;
      end
      if (cmd_i.clr_wait) begin
        wait_q <= '0;
      end
      if (cmd_i.open_frame) begin
        idle_q    <= '0;
        wait_q    <= '0;
        is_addr_q <= cmd_i.open_addr;
        len_q     <= '0;
        left_q    <= '0;
        pidx_q    <= '0;
        crc_cnt_q <= '0;
        exp_crc_q <= '0;
        crc_q     <= '1;
      end
      if (cmd_i.load_len) begin
        len_q  <= rx_byte_i;
        left_q <= rx_byte_i;
      end
      if (cmd_i.shift_crc) begin
        exp_crc_q <= {exp_crc_q[23:0], rx_byte_i};
        crc_cnt_q <= crc_cnt_q + 2'd1;
      end
      if (cmd_i.take_payload) begin
        crc_q        <= sbfr_pkg::crc_byte(crc_q, rx_byte_i);
        left_q       <= left_q - 8'd1;
        pidx_q       <= pidx_q + 8'd1;
        addr_shift_q <= {addr_shift_q[23:0], rx_byte_i};
      end
      if (cmd_i.load_ptr) begin
        ptr_q <= addr_shift_q;
      end
      if (cmd_i.advance_ptr) begin
        ptr_q <= ptr_q + {24'd0, len_q};
      end
      if (cmd_i.commit_clr) begin
        cidx_q <= '0;
      end else if (cmd_i.commit_inc) begin
        cidx_q <= cidx_q + 1'b1;
      end
    end
  end

  // Payload store: one write port for arriving bytes, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_payload && (pidx_q < MaxLen)) begin
      store[pidx_q[AW-1:0]] <= rx_byte_i;
    end
    rd_data_q <= store[cidx_q];
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      out_tx_q   <= (cmd_i.emit_kind == sbfr_pkg::KIND_TX) ? cmd_i.emit_tx : 8'd0;
      out_last_q <= cmd_i.emit_last;
      if (cmd_i.emit_kind == sbfr_pkg::KIND_WRITE) begin
        out_addr_q <= ptr_q + 32'(cidx_q);
        out_data_q <= rd_data_q;
      end else begin
        out_addr_q <= '0;
        out_data_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign tx_byte_o       = out_tx_q;
  assign write_address_o = out_addr_q;
  assign write_data_o    = out_data_q;
  assign last_o          = out_last_q;

endmodule
`default_nettype wire
